// ===== src/cra_pkg.sv =====
// ----------------------------------------------------------------------------
// cra_pkg: shared types and constants for the cyclotomic ring ALU
// Coefficient width, operation codes, stage payload structs and the
// operand width conversions.
// ----------------------------------------------------------------------------
package cra_pkg;

  localparam int COEF_W    = 32;             // internal coefficient width, 8..64
  localparam int FIELD_W   = 32;             // coefficient width on the ports
  localparam int NORM_W    = 64;
  localparam int DEXP_W    = 6;
  localparam int ROT_W     = 3;
  localparam int ROT_N     = 8;              // powers of w before wrap
  localparam int NUM_COEF  = 4;
  localparam int NUM_PROD  = 16;             // every a_i * b_j pair
  localparam int TZ_W      = $clog2(COEF_W);
  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 264;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_MUL   = 4'd2,
    KIND_ROT   = 4'd3,
    KIND_MSQ2  = 4'd4,
    KIND_DSQ2  = 4'd5,
    KIND_CONJ  = 4'd6,
    KIND_GDE   = 4'd7,
    KIND_NORM  = 4'd8
  } kind_e;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_vec_t;
  typedef logic [NUM_PROD-1:0][NORM_W-1:0] prod_vec_t;

  typedef struct packed {
    kind_e            kind;
    coef_vec_t        a;
    coef_vec_t        b;
    logic [ROT_W-1:0] rot;
  } op_t;

  typedef struct packed {
    coef_vec_t         r;
    logic [DEXP_W-1:0] dexp;
    logic              zero;
  } lin_t;

  typedef struct packed {
    logic [NUM_COEF-1:0][FIELD_W-1:0] r;
    logic [NORM_W-1:0]                nrat;
    logic [NORM_W-1:0]                nroot;
    logic [DEXP_W-1:0]                dexp;
    logic                             zero;
  } res_t;

  // port coefficient to internal width, wrapping or sign extending
  function automatic logic [COEF_W-1:0] to_coef(input logic [FIELD_W-1:0] x);
    logic signed [127:0] ext;
    ext = 128'(signed'(x));
    return ext[COEF_W-1:0];
  endfunction

  // internal coefficient back to the port width
  function automatic logic [FIELD_W-1:0] to_field(input logic [COEF_W-1:0] c);
    logic signed [127:0] ext;
    ext = 128'(signed'(c));
    return ext[FIELD_W-1:0];
  endfunction

endpackage

// ===== src/cra_lin_ops.sv =====
// ----------------------------------------------------------------------------
// cra_lin_ops: multiplier-free operations
// Add, subtract, rotation by w^k, sqrt2 scaling, conjugate and the
// sqrt2-adic exponent of the first operand.
// ----------------------------------------------------------------------------
module cra_lin_ops
  import cra_pkg::*;
(
  input  op_t  op_i,
  output lin_t lin_o
);

  coef_vec_t               sq2;
  logic [ROT_N-1:0][COEF_W-1:0] ring;
  logic [COEF_W-1:0]       any_bits;
  logic [COEF_W-1:0]       low_bit;
  logic [TZ_W-1:0]         tz;
  logic [NUM_COEF-1:0]     par;
  logic                    odd_step;
  logic [6:0]              expo;

  assign sq2[0] = op_i.a[1] - op_i.a[3];
  assign sq2[1] = op_i.a[2] + op_i.a[0];
  assign sq2[2] = op_i.a[1] + op_i.a[3];
  assign sq2[3] = op_i.a[2] - op_i.a[0];

  // w^4 = -1, so the powers of w walk through a, then -a
  always_comb begin
    for (int j = 0; j < NUM_COEF; j++) begin
      ring[j]            = op_i.a[j];
      ring[j + NUM_COEF] = COEF_W'(0) - op_i.a[j];
    end
  end

  // lowest set bit over all coefficients gives the common trailing zeros
  assign any_bits = op_i.a[0] | op_i.a[1] | op_i.a[2] | op_i.a[3];
  assign low_bit  = any_bits & (~any_bits + COEF_W'(1));

  always_comb begin
    tz = '0;
    for (int i = 0; i < COEF_W; i++) begin
      if (low_bit[i]) tz = tz | TZ_W'(i);
    end
    for (int j = 0; j < NUM_COEF; j++) begin
      par[j] = |(op_i.a[j] & low_bit);
    end
  end

  assign odd_step = (par[1] == par[3]) && (par[0] == par[2]);
  assign expo     = 7'({tz, 1'b0}) + 7'(odd_step);

  always_comb begin
    lin_o = '0;
    unique case (op_i.kind)
      KIND_ADD: begin
        for (int j = 0; j < NUM_COEF; j++) lin_o.r[j] = op_i.a[j] + op_i.b[j];
      end
      KIND_SUB: begin
        for (int j = 0; j < NUM_COEF; j++) lin_o.r[j] = op_i.a[j] - op_i.b[j];
      end
      KIND_ROT: begin
        for (int j = 0; j < NUM_COEF; j++) begin
          lin_o.r[j] = ring[ROT_W'(j) - op_i.rot];
        end
      end
      KIND_MSQ2: begin
        lin_o.r = sq2;
      end
      KIND_DSQ2: begin
        for (int j = 0; j < NUM_COEF; j++) begin
          lin_o.r[j] = COEF_W'(signed'(sq2[j]) >>> 1);
        end
      end
      KIND_CONJ: begin
        lin_o.r[0] = op_i.a[0];
        lin_o.r[1] = ring[7];
        lin_o.r[2] = ring[6];
        lin_o.r[3] = ring[5];
      end
      KIND_GDE: begin
        if (any_bits == '0) begin
          lin_o.zero = 1'b1;
        end else begin
          lin_o.dexp = (expo > 7'd63) ? 6'd63 : expo[DEXP_W-1:0];
        end
      end
      default: begin
        lin_o = '0;
      end
    endcase
  end

endmodule

// ===== src/cra_mult_array.sv =====
// ----------------------------------------------------------------------------
// cra_mult_array: registered product array
// Sixteen parallel signed products a_i * b_j; for the norm the second
// operand is replaced by the first so the same lanes give the squares.
// ----------------------------------------------------------------------------
module cra_mult_array
  import cra_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  op_t       op_i,
  output prod_vec_t prod_o
);

  coef_vec_t bsel;
  prod_vec_t prod_d;
  prod_vec_t prod_q;

  assign bsel = (op_i.kind == KIND_NORM) ? op_i.a : op_i.b;

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      for (int j = 0; j < NUM_COEF; j++) begin
        logic signed [2*COEF_W-1:0] full;
        logic signed [127:0]        wide;
        full = signed'(op_i.a[i]) * signed'(bsel[j]);
        wide = 128'(full);
        prod_d[i*NUM_COEF + j] = wide[NORM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== src/cra_combine.sv =====
// ----------------------------------------------------------------------------
// cra_combine: result assembly
// Sums the registered products into the negacyclic product or the norm
// and merges them with the multiplier-free results.
// ----------------------------------------------------------------------------
module cra_combine
  import cra_pkg::*;
(
  input  kind_e     kind_i,
  input  prod_vec_t prod_i,
  input  lin_t      lin_i,
  output res_t      res_o
);

  logic [NUM_COEF-1:0][NORM_W-1:0] msum;
  logic [NORM_W-1:0] nrat;
  logic [NORM_W-1:0] nroot;

  // prod_i[i*4+j] holds a_i * b_j
  assign msum[0] = prod_i[0]  - prod_i[13] - prod_i[10] - prod_i[7];
  assign msum[1] = prod_i[4]  + prod_i[1]  - prod_i[14] - prod_i[11];
  assign msum[2] = prod_i[8]  + prod_i[5]  + prod_i[2]  - prod_i[15];
  assign msum[3] = prod_i[12] + prod_i[9]  + prod_i[6]  + prod_i[3];

  assign nrat  = prod_i[0] + prod_i[5] + prod_i[10] + prod_i[15];
  assign nroot = prod_i[1] + prod_i[6] + prod_i[11] - prod_i[3];

  always_comb begin
    res_o      = '0;
    res_o.dexp = lin_i.dexp;
    res_o.zero = lin_i.zero;
    for (int j = 0; j < NUM_COEF; j++) begin
      if (kind_i == KIND_MUL) begin
        res_o.r[j] = to_field(msum[j][COEF_W-1:0]);
      end else begin
        res_o.r[j] = to_field(lin_i.r[j]);
      end
    end
    if (kind_i == KIND_NORM) begin
      res_o.nrat  = nrat;
      res_o.nroot = nroot;
    end
  end

endmodule

// ===== src/cyclotomic_ring_alu.sv =====
// ----------------------------------------------------------------------------
// cyclotomic_ring_alu: arithmetic unit for Z[w], w an eighth root of unity
//
//   channel   dir  tdata                                       tuser
//   s_axis    in   a0..a3, b0..b3 (32b each), rot_amount (3b)  kind (4b)
//   m_axis    out  r0..r3, norm_rational, norm_root_part,      operand_zero
//                  sqrt2_exp (6b)
//
// three register stages: operand register, product array register, result
// register; one item per cycle when the output is free, and an accepted item
// passes the product array and result registers in turn before it is offered.
// the product lane (32x32 multiplies) sets the stage boundary.
// reset clears the stage valid bits only; no clearing pass.
// a stalled output holds its stage; empty stages upstream still fill.
// ----------------------------------------------------------------------------
module cyclotomic_ring_alu
  import cra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a0 [31:0], a1, a2, a3, b0, b1, b2, b3 [255:224], rot_amount [258:256]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [3:0]
  input  logic [3:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // r0 [31:0], r1, r2, r3 [127:96], norm_rational [191:128],
  // norm_root_part [255:192], sqrt2_exp [261:256]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // operand_zero [0]
  output logic [0:0]            m_axis_tuser
);

  logic  v1_q, v2_q, v3_q;
  logic  adv1, adv2, adv3;
  op_t   op_d, op_q;
  lin_t  lin_d, lin_q;
  kind_e kind2_q;
  prod_vec_t prod;
  res_t  res_d, res_q;

  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready = adv1;

  always_comb begin
    op_d.kind = kind_e'(s_axis_tuser);
    for (int j = 0; j < NUM_COEF; j++) begin
      op_d.a[j] = to_coef(s_axis_tdata[FIELD_W*j +: FIELD_W]);
      op_d.b[j] = to_coef(s_axis_tdata[FIELD_W*(j+NUM_COEF) +: FIELD_W]);
    end
    op_d.rot = s_axis_tdata[2*NUM_COEF*FIELD_W +: ROT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) op_q <= op_d;
    if (adv2) begin
      kind2_q <= op_q.kind;
      lin_q   <= lin_d;
    end
    if (adv3) res_q <= res_d;
  end

  cra_lin_ops u_lin (
    .op_i  (op_q),
    .lin_o (lin_d)
  );

  cra_mult_array u_mult (
    .clk_i  (clk_i),
    .en_i   (adv2),
    .op_i   (op_q),
    .prod_o (prod)
  );

  cra_combine u_comb (
    .kind_i (kind2_q),
    .prod_i (prod),
    .lin_i  (lin_q),
    .res_o  (res_d)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {2'b00, res_q.dexp, res_q.nroot, res_q.nrat,
                          res_q.r[3], res_q.r[2], res_q.r[1], res_q.r[0]};
  assign m_axis_tuser  = res_q.zero;

`ifndef SYNTH
  // the zero flag only comes from the exponent operation, so all else is clear
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[261:256] == '0 && m_axis_tdata[255:0] == '0)
    else $error("operand_zero with nonzero result fields");

  // input back-pressure only when every stage holds an item
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v1_q && v2_q && v3_q)
    else $error("input stalled while a stage is empty");

  // an output item always comes from the product stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("output valid without an item in the product stage");
`endif

endmodule
